@@ sv/lcal_pkg.sv @@
// ----------------------------------------------------------------------------
// lcal_pkg
// Types and constants shared by the common-ancestor lifting block.
// ----------------------------------------------------------------------------
package lcal_pkg;

    localparam int NODE_BITS  = 10;
    localparam int NODE_SLOTS = 1 << NODE_BITS;
    localparam int LVL_BITS   = 5;

    typedef logic [NODE_BITS-1:0] node_t;
    typedef logic [LVL_BITS-1:0]  lvl_t;

    // opcodes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_NOT_BUILT = 2'd2;
    localparam logic [1:0] ST_CYCLE     = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        node_t      node_a;
        node_t      node_b;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        node_t      ancestor_node;
    } out_item_t;

    // memory requests from the sequencer
    typedef struct packed {
        logic  p_we;
        node_t p_waddr;
        node_t p_wdata;
        node_t p_raddr;
        logic  d_we;
        node_t d_waddr;
        node_t d_wdata;
        node_t d_raddr;
        logic  j_we;
        lvl_t  j_wlvl;
        node_t j_wnode;
        node_t j_wdata;
        lvl_t  j_rlvl;
        node_t j_rnode;
    } mem_req_t;

    // registered read data, valid in the cycle after the request
    typedef struct packed {
        node_t p_rdata;
        node_t d_rdata;
        node_t j_rdata;
    } mem_rsp_t;

endpackage

@@ sv/lowest_common_ancestor_lifting.sv @@
// ----------------------------------------------------------------------------
// lowest_common_ancestor_lifting
// Tree common-ancestor engine with parent load, table build and query.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  cfg     | in        | cfg_we             | cfg_wdata (node count)
//  s_      | in        | s_valid / s_ready  | s_data  (in_item_t)
//  m_      | out       | m_valid / m_ready  | m_data  (out_item_t)
//
//  A query lifts the deeper node by jumps; when the lifted nodes differ it
//  compares parents and runs an ascent pass over all levels until they meet.
//  Build: depth walk from each node to the root, then level zero, then above.
//  One item at a time; the next item enters while a result waits in m_.
//  Synchronous active-low reset; memories are not cleared.
// ----------------------------------------------------------------------------
module lowest_common_ancestor_lifting
    import lcal_pkg::*;
#(
    parameter int LEVELS = 10
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  node_t     cfg_wdata,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    mem_req_t  req;
    mem_rsp_t  rsp;
    logic      idle;
    logic      res_valid;
    logic      res_ready;
    out_item_t res_item;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    assign s_ready   = idle;
    assign res_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    lcal_ctrl #(.LEVELS(LEVELS)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .start     (s_valid && s_ready),
        .item      (s_data),
        .idle      (idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .req       (req),
        .rsp       (rsp)
    );

    lcal_store #(.LEVELS(LEVELS)) u_store (
        .aclk (aclk),
        .req  (req),
        .rsp  (rsp)
    );

endmodule

@@ sv/lcal_store.sv @@
// ----------------------------------------------------------------------------
// lcal_store
// Parent, depth and jump memories; one write and one registered read each.
// ----------------------------------------------------------------------------
module lcal_store
    import lcal_pkg::*;
#(
    parameter int LEVELS = 10
) (
    input  logic     aclk,
    input  mem_req_t req,
    output mem_rsp_t rsp
);

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    node_t parent_mem [0:NODE_SLOTS-1];
    node_t depth_mem  [0:NODE_SLOTS-1];
    node_t jump_mem   [0:LEVELS*NODE_SLOTS-1];

    logic [LW+NODE_BITS-1:0] j_wa;
    logic [LW+NODE_BITS-1:0] j_ra;

    assign j_wa = {req.j_wlvl[LW-1:0], req.j_wnode};
    assign j_ra = {req.j_rlvl[LW-1:0], req.j_rnode};

    // parent store
    always_ff @(posedge aclk) begin
        if (req.p_we) begin
            parent_mem[req.p_waddr] <= req.p_wdata;
        end
        rsp.p_rdata <= parent_mem[req.p_raddr];
    end

    // depth store
    always_ff @(posedge aclk) begin
        if (req.d_we) begin
            depth_mem[req.d_waddr] <= req.d_wdata;
        end
        rsp.d_rdata <= depth_mem[req.d_raddr];
    end

    // jump table, level in the upper address bits
    always_ff @(posedge aclk) begin
        if (req.j_we) begin
            jump_mem[j_wa] <= req.j_wdata;
        end
        rsp.j_rdata <= jump_mem[j_ra];
    end

endmodule

@@ sv/lcal_ctrl.sv @@
// ----------------------------------------------------------------------------
// lcal_ctrl
// Sequencer: parent loads, table build walks and lifting queries.
// ----------------------------------------------------------------------------
module lcal_ctrl
    import lcal_pkg::*;
#(
    parameter int LEVELS = 10
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  node_t     cfg_wdata,
    input  logic      start,
    input  in_item_t  item,
    output logic      idle,
    output logic      res_valid,
    input  logic      res_ready,
    output out_item_t res_item,
    output mem_req_t  req,
    input  mem_rsp_t  rsp
);

    typedef enum logic [21:0] {
        S_IDLE   = 22'h000001,
        S_DISP   = 22'h000002,
        S_BSTART = 22'h000004,
        S_BSTEP  = 22'h000008,
        S_BPWAIT = 22'h000010,
        S_J0RD   = 22'h000020,
        S_J0WR   = 22'h000040,
        S_JKRD1  = 22'h000080,
        S_JKRD2  = 22'h000100,
        S_JKWR   = 22'h000200,
        S_QDA    = 22'h000400,
        S_QDB    = 22'h000800,
        S_LSTEP  = 22'h001000,
        S_LWAIT  = 22'h002000,
        S_ASTART = 22'h004000,
        S_CRX    = 22'h008000,
        S_CRY    = 22'h010000,
        S_CCMP   = 22'h020000,
        S_SRX    = 22'h040000,
        S_SRY    = 22'h080000,
        S_SCMP   = 22'h100000,
        S_FINISH = 22'h200000
    } state_t;

    localparam lvl_t LVL_TOP = lvl_t'(LEVELS - 1);
    localparam node_t ROOT   = node_t'(1);

    state_t     state_reg, state_next;
    logic       ready_reg, ready_next;
    node_t      count_reg, count_next;
    in_item_t   item_reg, item_next;
    node_t      i_reg, i_next;
    node_t      cur_reg, cur_next;
    node_t      steps_reg, steps_next;
    node_t      x_reg, x_next;
    node_t      y_reg, y_next;
    node_t      d_reg, d_next;
    node_t      tmp_reg, tmp_next;
    lvl_t       k_reg, k_next;
    out_item_t  res_reg, res_next;

    function automatic logic in_range(input node_t v, input node_t n);
        in_range = (v != '0) && (v <= n);
    endfunction

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FINISH);
    assign res_item  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
            count_reg <= ROOT;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            count_reg <= count_next;
        end
        item_reg  <= item_next;
        i_reg     <= i_next;
        cur_reg   <= cur_next;
        steps_reg <= steps_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        d_reg     <= d_next;
        tmp_reg   <= tmp_next;
        k_reg     <= k_next;
        res_reg   <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        ready_next = ready_reg;
        count_next = count_reg;
        item_next  = item_reg;
        i_next     = i_reg;
        cur_next   = cur_reg;
        steps_next = steps_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        d_next     = d_reg;
        tmp_next   = tmp_reg;
        k_next     = k_reg;
        res_next   = res_reg;
        req        = '0;

        // register write: zero reads as one, clears the built flag
        if (cfg_we) begin
            count_next = (cfg_wdata == '0) ? ROOT : cfg_wdata;
            ready_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    item_next = item;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                res_next = '{status: ST_OK, ancestor_node: '0};
                state_next = S_FINISH;
                case (item_reg.opcode)
                    OP_LOAD: begin
                        if (item_reg.node_a < node_t'(2) ||
                            !in_range(item_reg.node_a, count_reg) ||
                            !in_range(item_reg.node_b, count_reg)) begin
                            res_next.status = ST_RANGE;
                        end else begin
                            req.p_we    = 1'b1;
                            req.p_waddr = item_reg.node_a;
                            req.p_wdata = item_reg.node_b;
                            ready_next  = 1'b0;
                        end
                    end
                    OP_BUILD: begin
                        ready_next = 1'b0;
                        i_next     = ROOT;
                        state_next = S_BSTART;
                    end
                    OP_QUERY: begin
                        if (!in_range(item_reg.node_a, count_reg) ||
                            !in_range(item_reg.node_b, count_reg)) begin
                            res_next.status = ST_RANGE;
                        end else if (!ready_reg) begin
                            res_next.status = ST_NOT_BUILT;
                        end else begin
                            req.d_raddr = item_reg.node_a;
                            state_next  = S_QDA;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // depth walk from node i up to the root
            S_BSTART: begin
                cur_next   = i_reg;
                steps_next = '0;
                state_next = S_BSTEP;
            end
            S_BSTEP: begin
                if (cur_reg == ROOT) begin
                    req.d_we    = 1'b1;
                    req.d_waddr = i_reg;
                    req.d_wdata = steps_reg;
                    if (i_reg == count_reg) begin
                        i_next     = ROOT;
                        state_next = S_J0RD;
                    end else begin
                        i_next     = i_reg + node_t'(1);
                        state_next = S_BSTART;
                    end
                end else if (steps_reg >= count_reg) begin
                    res_next   = '{status: ST_CYCLE, ancestor_node: '0};
                    state_next = S_FINISH;
                end else begin
                    req.p_raddr = cur_reg;
                    state_next  = S_BPWAIT;
                end
            end
            S_BPWAIT: begin
                if (!in_range(rsp.p_rdata, count_reg)) begin
                    res_next   = '{status: ST_RANGE, ancestor_node: '0};
                    state_next = S_FINISH;
                end else begin
                    cur_next   = rsp.p_rdata;
                    steps_next = steps_reg + node_t'(1);
                    state_next = S_BSTEP;
                end
            end
            // level zero: the parents
            S_J0RD: begin
                req.p_raddr = i_reg;
                state_next  = S_J0WR;
            end
            S_J0WR: begin
                req.j_we    = 1'b1;
                req.j_wlvl  = '0;
                req.j_wnode = i_reg;
                req.j_wdata = (i_reg == ROOT) ? ROOT : rsp.p_rdata;
                if (i_reg == count_reg) begin
                    if (LEVELS == 1) begin
                        ready_next = 1'b1;
                        res_next   = '{status: ST_OK, ancestor_node: '0};
                        state_next = S_FINISH;
                    end else begin
                        i_next     = ROOT;
                        k_next     = lvl_t'(1);
                        state_next = S_JKRD1;
                    end
                end else begin
                    i_next     = i_reg + node_t'(1);
                    state_next = S_J0RD;
                end
            end
            // level k from two reads of level k-1
            S_JKRD1: begin
                req.j_rlvl  = k_reg - lvl_t'(1);
                req.j_rnode = i_reg;
                state_next  = S_JKRD2;
            end
            S_JKRD2: begin
                req.j_rlvl  = k_reg - lvl_t'(1);
                req.j_rnode = rsp.j_rdata;
                state_next  = S_JKWR;
            end
            S_JKWR: begin
                req.j_we    = 1'b1;
                req.j_wlvl  = k_reg;
                req.j_wnode = i_reg;
                req.j_wdata = rsp.j_rdata;
                state_next  = S_JKRD1;
                if (i_reg == count_reg) begin
                    if (k_reg == LVL_TOP) begin
                        ready_next = 1'b1;
                        res_next   = '{status: ST_OK, ancestor_node: '0};
                        state_next = S_FINISH;
                    end else begin
                        k_next = k_reg + lvl_t'(1);
                        i_next = ROOT;
                    end
                end else begin
                    i_next = i_reg + node_t'(1);
                end
            end
            // query: fetch both depths
            S_QDA: begin
                tmp_next    = rsp.d_rdata;
                req.d_raddr = item_reg.node_b;
                state_next  = S_QDB;
            end
            S_QDB: begin
                if (tmp_reg < rsp.d_rdata) begin
                    x_next = item_reg.node_b;
                    y_next = item_reg.node_a;
                    d_next = rsp.d_rdata - tmp_reg;
                end else begin
                    x_next = item_reg.node_a;
                    y_next = item_reg.node_b;
                    d_next = tmp_reg - rsp.d_rdata;
                end
                k_next     = LVL_TOP;
                state_next = S_LSTEP;
            end
            // lift the deeper node
            S_LSTEP: begin
                if ((d_reg >> k_reg) != '0) begin
                    req.j_rlvl  = k_reg;
                    req.j_rnode = x_reg;
                    state_next  = S_LWAIT;
                end else if (k_reg == '0) begin
                    state_next = S_ASTART;
                end else begin
                    k_next = k_reg - lvl_t'(1);
                end
            end
            S_LWAIT: begin
                x_next     = rsp.j_rdata;
                d_next     = d_reg - (node_t'(1) << k_reg);
                state_next = S_LSTEP;
            end
            S_ASTART: begin
                if (x_reg == y_reg) begin
                    res_next   = '{status: ST_OK, ancestor_node: x_reg};
                    state_next = S_FINISH;
                end else begin
                    state_next = S_CRX;
                end
            end
            // compare parents of x and y
            S_CRX: begin
                req.j_rnode = x_reg;
                state_next  = S_CRY;
            end
            S_CRY: begin
                tmp_next    = rsp.j_rdata;
                req.j_rnode = y_reg;
                state_next  = S_CCMP;
            end
            S_CCMP: begin
                if (tmp_reg == rsp.j_rdata) begin
                    res_next   = '{status: ST_OK, ancestor_node: tmp_reg};
                    state_next = S_FINISH;
                end else begin
                    k_next     = LVL_TOP;
                    state_next = S_SRX;
                end
            end
            // one ascent pass, top level down
            S_SRX: begin
                req.j_rlvl  = k_reg;
                req.j_rnode = x_reg;
                state_next  = S_SRY;
            end
            S_SRY: begin
                tmp_next    = rsp.j_rdata;
                req.j_rlvl  = k_reg;
                req.j_rnode = y_reg;
                state_next  = S_SCMP;
            end
            S_SCMP: begin
                if (tmp_reg != rsp.j_rdata) begin
                    x_next = tmp_reg;
                    y_next = rsp.j_rdata;
                end
                if (k_reg == '0) begin
                    state_next = S_CRX;
                end else begin
                    k_next     = k_reg - lvl_t'(1);
                    state_next = S_SRX;
                end
            end
            S_FINISH: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/lcal_checker.sv @@
// ----------------------------------------------------------------------------
// lcal_checker
// Port-level checks on the common-ancestor block, bound to the top level.
// ----------------------------------------------------------------------------
module lcal_checker
    import lcal_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // failures carry no ancestor
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.ancestor_node == '0)
        else $error("ancestor on failed item");

    // an accepted item leaves the input not ready in the next cycle
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

endmodule

bind lowest_common_ancestor_lifting lcal_checker u_lcal_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ dv/lcal_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcal_scoreboard
// Watches the config port and both item channels of the common-ancestor
// block, predicts each result from its own copy of the tree and compares.
// ----------------------------------------------------------------------------
module lcal_scoreboard
    import lcal_pkg::*;
#(
    parameter int LEVELS = 10
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  node_t     cfg_wdata,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_data,
    output int        errors,
    output int        pending
);

    // predictor state
    node_t       parent_tab [NODE_SLOTS];
    int unsigned depth_tab  [NODE_SLOTS];
    node_t       hop_tab    [LEVELS][NODE_SLOTS];
    bit          tree_built;
    int unsigned tree_size;
    out_item_t   answers_due[$];

    assign pending = answers_due.size();

    function automatic bit in_tree(int unsigned v);
        return v >= 1 && v <= tree_size;
    endfunction

    function automatic int unsigned parent_of(int unsigned v);
        return (v == 1) ? 1 : int'(parent_tab[v]);
    endfunction

    // depth walk over all nodes, then the ancestor levels
    function automatic logic [1:0] build_tree();
        int unsigned steps, cur;
        tree_built = 1'b0;
        for (int unsigned i = 1; i <= tree_size; i++) begin
            steps = 0;
            cur   = i;
            while (cur != 1) begin
                if (steps >= tree_size) return ST_CYCLE;
                cur = parent_of(cur);
                if (!in_tree(cur)) return ST_RANGE;
                steps++;
            end
            depth_tab[i] = steps;
        end
        for (int unsigned v = 1; v <= tree_size; v++) hop_tab[0][v] = node_t'(parent_of(v));
        for (int k = 1; k < LEVELS; k++)
            for (int unsigned v = 1; v <= tree_size; v++)
                hop_tab[k][v] = hop_tab[k-1][hop_tab[k-1][v]];
        tree_built = 1'b1;
        return ST_OK;
    endfunction

    function automatic node_t meet_point(node_t x, node_t y);
        node_t       t;
        int unsigned gap;
        if (depth_tab[x] < depth_tab[y]) begin
            t = x; x = y; y = t;
        end
        gap = depth_tab[x] - depth_tab[y];
        for (int k = LEVELS - 1; k >= 0; k--) begin
            while (gap >= (1 << k)) begin
                gap -= (1 << k);
                x = hop_tab[k][x];
            end
        end
        if (x == y) return x;
        while (hop_tab[0][x] != hop_tab[0][y]) begin
            for (int k = LEVELS - 1; k >= 0; k--) begin
                if (hop_tab[k][x] != hop_tab[k][y]) begin
                    x = hop_tab[k][x];
                    y = hop_tab[k][y];
                end
            end
        end
        return hop_tab[0][x];
    endfunction

    function automatic out_item_t predict(in_item_t it);
        out_item_t r;
        r = '0;
        case (it.opcode)
            OP_LOAD: begin
                if (it.node_a < 2 || !in_tree(it.node_a) || !in_tree(it.node_b)) begin
                    r.status = ST_RANGE;
                end else begin
                    parent_tab[it.node_a] = it.node_b;
                    tree_built = 1'b0;
                end
            end
            OP_BUILD: r.status = build_tree();
            OP_QUERY: begin
                if (!in_tree(it.node_a) || !in_tree(it.node_b)) r.status = ST_RANGE;
                else if (!tree_built) r.status = ST_NOT_BUILT;
                else r.ancestor_node = meet_point(it.node_a, it.node_b);
            end
            default: ;
        endcase
        return r;
    endfunction

    // sample on the rising edge
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            tree_built = 1'b0;
            tree_size  = 1;
            answers_due.delete();
            errors     = 0;
        end else begin
            if (cfg_we) begin
                tree_size  = (cfg_wdata == 0) ? 1 : int'(cfg_wdata);
                tree_built = 1'b0;
            end
            if (s_valid && s_ready) answers_due = {answers_due, predict(s_data)};
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected item status=%0d anc=%0d",
                                 $time, m_data.status, m_data.ancestor_node);
                end else begin
                    want = answers_due.pop_front();
                    if (want.status != m_data.status
                        || want.ancestor_node != m_data.ancestor_node) begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch exp status=%0d anc=%0d got status=%0d anc=%0d",
                                     $time, want.status, want.ancestor_node,
                                     m_data.status, m_data.ancestor_node);
                    end
                end
            end
        end
    end

endmodule

@@ dv/tb_lowest_common_ancestor_lifting.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lowest_common_ancestor_lifting
// Loads random trees, builds the lifting tables and queries common ancestors
// under varying idle and stall rates; a checker module scores every item.
// ----------------------------------------------------------------------------
module tb_lowest_common_ancestor_lifting;
    import lcal_pkg::*;

    localparam logic [1:0] OP_SPARE   = 2'd3;
    localparam int         CYCLE_CAP  = 4000000;
    localparam int         ITEM_GOAL  = 1700;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_we = 1'b0;
    node_t     cfg_wdata = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int  errors, pending;
    int  cycles = 0;
    int  items_sent = 0;
    int  s_idle_pct = 0;
    int  m_stall_pct = 0;
    bit  hold_rx = 1'b0;
    int  cur_size = 1;
    bit  loaded [NODE_SLOTS];

    always #5 aclk = ~aclk;

    lowest_common_ancestor_lifting dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    lcal_scoreboard chk (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .errors(errors), .pending(pending)
    );

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("lowest_common_ancestor_lifting test failed");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge aclk) begin
        m_ready <= !hold_rx && ($urandom_range(99) >= m_stall_pct);
    end

    // one item; valid stays up into the next call unless the sender idles
    task automatic send_item(logic [1:0] op, int a, int b);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{opcode: op, node_a: node_t'(a), node_b: node_t'(b)};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
        if (op == OP_LOAD && a >= 2 && a <= cur_size && b >= 1 && b <= cur_size)
            loaded[a] = 1'b1;
    endtask

    // stop offering and wait for every result
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic set_size(int v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= node_t'(v);
        @(negedge aclk);
        cfg_we    <= 1'b0;
        cur_size  = (v == 0) ? 1 : v;
    endtask

    // chain or random shallow tree over 2..size
    task automatic load_tree(bit chain);
        for (int i = 2; i <= cur_size; i++)
            send_item(OP_LOAD, i, chain ? i - 1 : $urandom_range(1, i - 1));
    endtask

    task automatic run_queries(int count);
        int pick;
        for (int q = 0; q < count; q++) begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_item(OP_QUERY, $urandom_range(1023), $urandom_range(1023));
            else if (pick < 12)
                send_item(OP_SPARE, $urandom_range(1023), $urandom_range(1023));
            else if (pick < 17)
                send_item(OP_LOAD, $urandom_range(1023), $urandom_range(1023));
            else
                send_item(OP_QUERY, $urandom_range(1, cur_size), $urandom_range(1, cur_size));
        end
    endtask

    initial begin
        int round;
        bit all_loaded;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: single node tree, bad nodes, spare opcode
        send_item(OP_QUERY, 1, 1);
        send_item(OP_BUILD, 0, 0);
        send_item(OP_QUERY, 1, 1);
        send_item(OP_QUERY, 0, 1023);
        send_item(OP_LOAD, 1, 1);
        send_item(OP_SPARE, 1023, 1023);
        set_size(0);
        send_item(OP_QUERY, 1, 1);
        set_size(1023);
        send_item(OP_LOAD, 1023, 1022);

        // directed: small known tree
        set_size(8);
        send_item(OP_LOAD, 2, 1); send_item(OP_LOAD, 3, 1); send_item(OP_LOAD, 4, 2);
        send_item(OP_LOAD, 5, 2); send_item(OP_LOAD, 6, 3); send_item(OP_LOAD, 7, 4);
        send_item(OP_LOAD, 8, 7);
        send_item(OP_QUERY, 8, 5);
        send_item(OP_BUILD, 0, 0);
        send_item(OP_QUERY, 8, 5); send_item(OP_QUERY, 8, 6); send_item(OP_QUERY, 7, 4);
        send_item(OP_QUERY, 1, 8); send_item(OP_QUERY, 9, 1);
        send_item(OP_LOAD, 9, 1); send_item(OP_LOAD, 0, 1); send_item(OP_LOAD, 3, 0);
        // self loop gives a cycle, repair it
        send_item(OP_LOAD, 3, 3); send_item(OP_BUILD, 0, 0);
        send_item(OP_LOAD, 3, 1); send_item(OP_BUILD, 0, 0);
        // parent beyond the shrunk tree
        send_item(OP_LOAD, 5, 7);
        set_size(5);
        send_item(OP_BUILD, 0, 0);

        // random rounds
        round = 0;
        while (items_sent < ITEM_GOAL) begin
            case (round % 4)
                0: begin s_idle_pct = 0;  m_stall_pct = 0;  end
                1: begin s_idle_pct = 88; m_stall_pct = 0;  end
                2: begin s_idle_pct = 0;  m_stall_pct = 88; end
                default: begin s_idle_pct = 12; m_stall_pct = 12; end
            endcase
            if (round == 1) begin
                // largest tree, kept shallow, no idling
                s_idle_pct = 0; m_stall_pct = 0;
                set_size(1023);
                load_tree(1'b0);
            end else begin
                set_size($urandom_range(2, 40));
                load_tree($urandom_range(3) == 0);
            end
            if ($urandom_range(5) == 0) send_item(OP_QUERY, 1, cur_size);
            if ($urandom_range(5) == 0 && cur_size > 2) begin
                send_item(OP_LOAD, cur_size, cur_size);
                send_item(OP_BUILD, 0, 0);
                send_item(OP_LOAD, cur_size, 1);
            end
            all_loaded = 1'b1;
            for (int i = 2; i <= cur_size; i++) if (!loaded[i]) all_loaded = 1'b0;
            if (all_loaded) send_item(OP_BUILD, 0, 0);
            if (round == 3) begin
                // long receiver hold-off while items keep coming
                fork
                    begin
                        hold_rx = 1'b1;
                        repeat (600) @(posedge aclk);
                        hold_rx = 1'b0;
                    end
                join_none
            end
            run_queries($urandom_range(10, 40));
            if (round % 5 == 4) drain();
            round++;
        end

        drain();
        repeat (200) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("lowest_common_ancestor_lifting test passed");
        else
            $display("lowest_common_ancestor_lifting test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/lcal_pkg.sv
sv/lcal_store.sv
sv/lcal_ctrl.sv
sv/lowest_common_ancestor_lifting.sv
sv/lcal_checker.sv
dv/lcal_checker.sv
dv/tb_lowest_common_ancestor_lifting.sv
